[rtl/dpst_pkg.sv]
// Shared types, widths, register codes and reset values for the DOA peak source tracker.
// Used by the top level and by the port checker.
package dpst_pkg;

   localparam int BIN_W      = 6;
   localparam int SRC_W      = 16;
   localparam int LMIN_W     = 16;
   localparam int ANGLE_W    = 6;
   localparam int CMIN_W     = 4;
   localparam int HOLD_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int DEF_NUM_BINS    = 37;
   localparam int DEF_HISTORY_LEN = 10;
   localparam int DEF_LIK_WIDTH   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LIK_MIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_SRC    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ANGLE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSIST    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD       = 3'd4;

   localparam logic [LMIN_W-1:0]  RST_LIK_MIN   = 16'd32768;
   localparam logic [LMIN_W-1:0]  RST_NEW_SRC   = 16'd39322;
   localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE = 6'd4;
   localparam logic [CMIN_W-1:0]  RST_CONSIST   = 4'd6;
   localparam logic [HOLD_W-1:0]  RST_HOLD      = 4'd10;

   typedef struct packed {
      logic             valid;
      logic [BIN_W-1:0] bin;
   } peak_type;

endpackage

[rtl/doa_peak_source_tracker_top.sv]
// DOA peak source tracker: per-frame peak search, history match walk and track hold logic.
// Depends on dpst_pkg.
//
//   channel | direction | handshake             | word
//   req_    | in        | req_valid/req_ready   | likelihood, last_bin
//   rsp_    | out       | rsp_valid/rsp_ready   | track, id, current and assigned bins
//   csr_    | in        | csr_valid/csr_ready   | register index, write data
//
// A bin that does not end the frame is accepted, then takes one pass of the compare unit.
// The final bin also walks the history when the frame has a peak (one compare per history
// entry), then decides once the previous result is no longer waiting on rsp_ready.
// Synchronous reset clears all track state and the history; csr_ready is always high.
module doa_peak_source_tracker_top
   import dpst_pkg::*;
#(
   parameter int NUM_BINS    = DEF_NUM_BINS,
   parameter int HISTORY_LEN = DEF_HISTORY_LEN,
   parameter int LIK_WIDTH   = DEF_LIK_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [LIK_WIDTH-1:0]  req_likelihood,
   input  logic                  req_last_bin,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_track_active,
   output logic [SRC_W-1:0]      rsp_source_id,
   output logic                  rsp_current_valid,
   output logic [BIN_W-1:0]      rsp_current_bin,
   output logic                  rsp_assigned_valid,
   output logic [BIN_W-1:0]      rsp_assigned_bin,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W   = $clog2(NUM_BINS + 1);
   localparam int IDX_W   = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
   localparam int MATCH_W = $clog2(HISTORY_LEN + 1);
   localparam int CMP_W   = (LIK_WIDTH > LMIN_W) ? LIK_WIDTH : LMIN_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_BIN    = 2'd1;
   localparam logic [1:0] S_WALK   = 2'd2;
   localparam logic [1:0] S_DECIDE = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [LIK_WIDTH-1:0] lik_ff, lik_in;
   logic                 last_ff, last_in;

   logic [LMIN_W-1:0]    lik_min_ff, lik_min_in;
   logic [LMIN_W-1:0]    new_src_ff, new_src_in;
   logic [ANGLE_W-1:0]   max_angle_ff, max_angle_in;
   logic [CMIN_W-1:0]    consist_ff, consist_in;
   logic [HOLD_W-1:0]    hold_frames_ff, hold_frames_in;

   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [LIK_WIDTH-1:0] max_ff, max_in;
   logic [BIN_W-1:0]     max_bin_ff, max_bin_in;
   logic                 found_ff, found_in;

   peak_type             hist_ff [HISTORY_LEN];
   peak_type             hist_in [HISTORY_LEN];
   peak_type             prev_ff, prev_in;
   peak_type             asg_ff, asg_in;
   logic [IDX_W-1:0]     walk_idx_ff, walk_idx_in;
   logic [MATCH_W-1:0]   matches_ff, matches_in;
   logic [HOLD_W-1:0]    hold_ff, hold_in;
   logic [SRC_W-1:0]     src_ff, src_in;
   logic                 trk_ff, trk_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_trk_ff, rsp_trk_in;
   logic [SRC_W-1:0]     rsp_src_ff, rsp_src_in;
   peak_type             rsp_cur_ff, rsp_cur_in;
   peak_type             rsp_asg_ff, rsp_asg_in;

   logic [CMP_W-1:0]     cmp_a, cmp_b;
   logic                 cmp_gt;
   peak_type             hsel;
   logic [BIN_W-1:0]     bin_gap;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   assign hsel    = hist_ff[walk_idx_ff];
   assign bin_gap = (hsel.bin > max_bin_ff) ? (hsel.bin - max_bin_ff) : (max_bin_ff - hsel.bin);

   always_comb begin
      unique case (state_ff)
         S_BIN: begin
            cmp_a = CMP_W'(lik_ff);
            cmp_b = found_ff ? CMP_W'(max_ff) : CMP_W'(lik_min_ff);
         end
         S_WALK: begin
            cmp_a = CMP_W'(bin_gap);
            cmp_b = CMP_W'(max_angle_ff);
         end
         default: begin
            cmp_a = CMP_W'(max_ff);
            cmp_b = CMP_W'(new_src_ff);
         end
      endcase
      cmp_gt = (cmp_a > cmp_b);
   end

   always_comb begin
      logic consistent;
      consistent     = 1'b0;
      state_in       = state_ff;
      lik_in         = lik_ff;
      last_in        = last_ff;
      lik_min_in     = lik_min_ff;
      new_src_in     = new_src_ff;
      max_angle_in   = max_angle_ff;
      consist_in     = consist_ff;
      hold_frames_in = hold_frames_ff;
      cnt_in         = cnt_ff;
      max_in         = max_ff;
      max_bin_in     = max_bin_ff;
      found_in       = found_ff;
      hist_in        = hist_ff;
      prev_in        = prev_ff;
      asg_in         = asg_ff;
      walk_idx_in    = walk_idx_ff;
      matches_in     = matches_ff;
      hold_in        = hold_ff;
      src_in         = src_ff;
      trk_in         = trk_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_trk_in     = rsp_trk_ff;
      rsp_src_in     = rsp_src_ff;
      rsp_cur_in     = rsp_cur_ff;
      rsp_asg_in     = rsp_asg_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_LIK_MIN:   lik_min_in     = csr_wdata;
            CSR_NEW_SRC:   new_src_in     = csr_wdata;
            CSR_MAX_ANGLE: max_angle_in   = csr_wdata[ANGLE_W-1:0];
            CSR_CONSIST:   consist_in     = csr_wdata[CMIN_W-1:0];
            CSR_HOLD:      hold_frames_in = csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               lik_in   = req_likelihood;
               last_in  = req_last_bin;
               state_in = S_BIN;
            end
         end
         S_BIN: begin
            if (cnt_ff < CNT_W'(NUM_BINS)) begin
               if (cmp_gt) begin
                  max_in     = lik_ff;
                  max_bin_in = BIN_W'(cnt_ff);
                  found_in   = 1'b1;
               end
               cnt_in = cnt_ff + 1'b1;
            end
            if (last_ff) begin
               for (int i = 0; i < HISTORY_LEN - 1; i++) begin
                  hist_in[i] = hist_ff[i+1];
               end
               hist_in[HISTORY_LEN-1] = prev_ff;
               prev_in.valid = found_in;
               prev_in.bin   = max_bin_in;
               walk_idx_in   = '0;
               matches_in    = '0;
               state_in      = found_in ? S_WALK : S_DECIDE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (hsel.valid && !cmp_gt) begin
               matches_in = matches_ff + 1'b1;
            end
            if (walk_idx_ff == IDX_W'(HISTORY_LEN - 1)) begin
               state_in = S_DECIDE;
            end else begin
               walk_idx_in = walk_idx_ff + 1'b1;
            end
         end
         default: begin
            if (!rsp_valid_ff || rsp_ready) begin
               consistent = found_ff && (32'(matches_ff) >= 32'(consist_ff));
               if (consistent) begin
                  if (hold_ff == '0) begin
                     if (cmp_gt) begin
                        src_in  = src_ff + 1'b1;
                        hold_in = hold_frames_ff;
                        trk_in  = 1'b1;
                     end
                  end else begin
                     hold_in = hold_frames_ff;
                  end
               end else if (hold_ff != '0) begin
                  hold_in = hold_ff - 1'b1;
                  if (hold_ff == HOLD_W'(1)) begin
                     trk_in = 1'b0;
                  end
               end
               asg_in = '0;
               if (hold_in != '0) begin
                  if (consistent) begin
                     asg_in.valid = 1'b1;
                     asg_in.bin   = max_bin_ff;
                  end else if (trk_in) begin
                     asg_in = asg_ff;
                  end
               end
               rsp_valid_in     = 1'b1;
               rsp_trk_in       = trk_in;
               rsp_src_in       = src_in;
               rsp_cur_in.valid = found_ff;
               rsp_cur_in.bin   = max_bin_ff;
               rsp_asg_in       = asg_in;
               cnt_in           = '0;
               max_in           = '0;
               max_bin_in       = '0;
               found_in         = 1'b0;
               state_in         = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lik_ff      <= lik_in;
      last_ff     <= last_in;
      walk_idx_ff <= walk_idx_in;
      matches_ff  <= matches_in;
      rsp_trk_ff  <= rsp_trk_in;
      rsp_src_ff  <= rsp_src_in;
      rsp_cur_ff  <= rsp_cur_in;
      rsp_asg_ff  <= rsp_asg_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         lik_min_ff     <= RST_LIK_MIN;
         new_src_ff     <= RST_NEW_SRC;
         max_angle_ff   <= RST_MAX_ANGLE;
         consist_ff     <= RST_CONSIST;
         hold_frames_ff <= RST_HOLD;
         cnt_ff         <= '0;
         max_ff         <= '0;
         max_bin_ff     <= '0;
         found_ff       <= 1'b0;
         for (int i = 0; i < HISTORY_LEN; i++) begin
            hist_ff[i] <= '0;
         end
         prev_ff        <= '0;
         asg_ff         <= '0;
         hold_ff        <= '0;
         src_ff         <= '0;
         trk_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         lik_min_ff     <= lik_min_in;
         new_src_ff     <= new_src_in;
         max_angle_ff   <= max_angle_in;
         consist_ff     <= consist_in;
         hold_frames_ff <= hold_frames_in;
         cnt_ff         <= cnt_in;
         max_ff         <= max_in;
         max_bin_ff     <= max_bin_in;
         found_ff       <= found_in;
         hist_ff        <= hist_in;
         prev_ff        <= prev_in;
         asg_ff         <= asg_in;
         hold_ff        <= hold_in;
         src_ff         <= src_in;
         trk_ff         <= trk_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_track_active   = rsp_trk_ff;
   assign rsp_source_id      = rsp_src_ff;
   assign rsp_current_valid  = rsp_cur_ff.valid;
   assign rsp_current_bin    = rsp_cur_ff.valid ? rsp_cur_ff.bin : '0;
   assign rsp_assigned_valid = rsp_asg_ff.valid;
   assign rsp_assigned_bin   = rsp_asg_ff.valid ? rsp_asg_ff.bin : '0;

endmodule

[rtl/dpst_checker.sv]
// Port checker for the DOA peak source tracker, bound to the top level.
// Depends on dpst_pkg; sees the result ports and req_ready only.
module dpst_checker
   import dpst_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_track_active,
   input logic [SRC_W-1:0] rsp_source_id,
   input logic             rsp_current_valid,
   input logic [BIN_W-1:0] rsp_current_bin,
   input logic             rsp_assigned_valid,
   input logic [BIN_W-1:0] rsp_assigned_bin
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_source_id)
         && $stable(rsp_current_bin) && $stable(rsp_assigned_bin))
      else $error("result word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result or busy state survives reset");

   a_cur_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_current_valid |-> rsp_current_bin == '0)
      else $error("current bin set without a valid peak");

   a_asg_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_assigned_valid |-> rsp_track_active)
      else $error("direction assigned while no track is active");

   a_asg_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_assigned_valid |-> rsp_assigned_bin == '0)
      else $error("assigned bin set without an assigned direction");

endmodule

bind doa_peak_source_tracker_top dpst_checker u_dpst_checker (.*);

[verif/tb_top.sv]
// Testbench for doa_peak_source_tracker_top: streams likelihood bins and register writes,
// predicts every frame report with a behavioral tracker and compares it field by field.
// Depends on dpst_pkg and doa_peak_source_tracker_top.
module tb_top;
   import dpst_pkg::*;

   localparam int NUM_BINS        = DEF_NUM_BINS;
   localparam int HISTORY_LEN     = DEF_HISTORY_LEN;
   localparam int LIK_W           = DEF_LIK_WIDTH;
   localparam int SETTLE_CYCLES   = DEF_HISTORY_LEN + 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;

   typedef struct packed {
      logic             track_active;
      logic [SRC_W-1:0] source_id;
      logic             current_valid;
      logic [BIN_W-1:0] current_bin;
      logic             assigned_valid;
      logic [BIN_W-1:0] assigned_bin;
   } frame_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [LIK_W-1:0]      req_likelihood = '0;
   logic                  req_last_bin = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_track_active;
   logic [SRC_W-1:0]      rsp_source_id;
   logic                  rsp_current_valid;
   logic [BIN_W-1:0]      rsp_current_bin;
   logic                  rsp_assigned_valid;
   logic [BIN_W-1:0]      rsp_assigned_bin;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // tracker model: registers and frame state
   logic [LMIN_W-1:0]  lik_min_cfg;
   logic [LMIN_W-1:0]  new_src_cfg;
   logic [ANGLE_W-1:0] angle_cfg;
   logic [CMIN_W-1:0]  consist_cfg;
   logic [HOLD_W-1:0]  hold_cfg;
   logic [BIN_W-1:0]   bin_pos;
   logic [LIK_W-1:0]   peak_lik;
   logic [BIN_W-1:0]   peak_bin;
   logic               peak_seen;
   peak_type           past_peaks [HISTORY_LEN];
   peak_type           last_frame_peak;
   logic [HOLD_W-1:0]  hold_left;
   logic [SRC_W-1:0]   source_num;
   logic               tracking;
   peak_type           steer_dir;
   frame_report_type   frame_reports_due [$];

   int send_idle_pct;
   int recv_idle_pct;
   int bins_sent;
   int reports_checked;
   int mismatches;
   int hold_off_asked;
   int hold_off_granted = 0;
   int hold_off_left = 0;
   int quiet_cycles;

   doa_peak_source_tracker_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_likelihood     (req_likelihood),
      .req_last_bin       (req_last_bin),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_track_active   (rsp_track_active),
      .rsp_source_id      (rsp_source_id),
      .rsp_current_valid  (rsp_current_valid),
      .rsp_current_bin    (rsp_current_bin),
      .rsp_assigned_valid (rsp_assigned_valid),
      .rsp_assigned_bin   (rsp_assigned_bin),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void reset_tracker();
      lik_min_cfg     = RST_LIK_MIN;
      new_src_cfg     = RST_NEW_SRC;
      angle_cfg       = RST_MAX_ANGLE;
      consist_cfg     = RST_CONSIST;
      hold_cfg        = RST_HOLD;
      bin_pos         = '0;
      peak_lik        = '0;
      peak_bin        = '0;
      peak_seen       = 1'b0;
      foreach (past_peaks[i]) past_peaks[i] = '0;
      last_frame_peak = '0;
      hold_left       = '0;
      source_num      = '0;
      tracking        = 1'b0;
      steer_dir       = '0;
   endfunction

   function automatic void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_LIK_MIN:   lik_min_cfg = data[LMIN_W-1:0];
         CSR_NEW_SRC:   new_src_cfg = data[LMIN_W-1:0];
         CSR_MAX_ANGLE: angle_cfg   = data[ANGLE_W-1:0];
         CSR_CONSIST:   consist_cfg = data[CMIN_W-1:0];
         CSR_HOLD:      hold_cfg    = data[HOLD_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void track_bin(logic [LIK_W-1:0] lik, logic last);
      peak_type         cur;
      peak_type         kept;
      logic [LIK_W-1:0] cur_lik;
      logic [BIN_W-1:0] diff;
      int               hits;
      logic             consistent;
      frame_report_type rep;
      hits       = 0;
      consistent = 1'b0;
      if (bin_pos < NUM_BINS) begin
         if (lik > (peak_seen ? peak_lik : lik_min_cfg)) begin
            peak_lik  = lik;
            peak_bin  = bin_pos;
            peak_seen = 1'b1;
         end
         bin_pos++;
      end
      if (!last) return;
      cur.valid = peak_seen;
      cur.bin   = peak_seen ? peak_bin : '0;
      cur_lik   = peak_lik;
      for (int i = 0; i < HISTORY_LEN - 1; i++) past_peaks[i] = past_peaks[i+1];
      past_peaks[HISTORY_LEN-1] = last_frame_peak;
      last_frame_peak = cur;
      if (cur.valid) begin
         foreach (past_peaks[i]) begin
            if (past_peaks[i].valid) begin
               diff = (past_peaks[i].bin > cur.bin) ? past_peaks[i].bin - cur.bin
                                                    : cur.bin - past_peaks[i].bin;
               if (diff <= angle_cfg) hits++;
            end
         end
         consistent = (hits >= int'(consist_cfg));
      end
      if (consistent) begin
         if (hold_left == 0) begin
            if (cur_lik > new_src_cfg) begin
               source_num++;
               hold_left = hold_cfg;
               tracking  = 1'b1;
            end
         end else begin
            hold_left = hold_cfg;
         end
      end else if (hold_left > 0) begin
         hold_left--;
         if (hold_left == 0) tracking = 1'b0;
      end
      kept      = steer_dir;
      steer_dir = '0;
      if (hold_left > 0) begin
         if (consistent) steer_dir = cur;
         else if (tracking) steer_dir = kept;
      end
      rep.track_active   = tracking;
      rep.source_id      = source_num;
      rep.current_valid  = cur.valid;
      rep.current_bin    = cur.bin;
      rep.assigned_valid = steer_dir.valid;
      rep.assigned_bin   = steer_dir.valid ? steer_dir.bin : '0;
      frame_reports_due = {frame_reports_due, rep};
      bin_pos   = '0;
      peak_lik  = '0;
      peak_bin  = '0;
      peak_seen = 1'b0;
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      frame_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_reports_due.size() == 0) begin
            $error("frame report with none expected: source_id %0d", rsp_source_id);
            mismatches++;
         end else begin
            want = frame_reports_due.pop_front();
            compare_field("track_active", int'(want.track_active), int'(rsp_track_active));
            compare_field("source_id", int'(want.source_id), int'(rsp_source_id));
            compare_field("current_valid", int'(want.current_valid), int'(rsp_current_valid));
            compare_field("current_bin", int'(want.current_bin), int'(rsp_current_bin));
            compare_field("assigned_valid", int'(want.assigned_valid),
                          int'(rsp_assigned_valid));
            compare_field("assigned_bin", int'(want.assigned_bin), int'(rsp_assigned_bin));
         end
         reports_checked++;
      end
   end

   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready     <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_granted != hold_off_asked) begin
         rsp_ready        <= 1'b0;
         hold_off_left    <= HOLD_OFF_CYCLES;
         hold_off_granted <= hold_off_granted + 1;
      end else begin
         rsp_ready <= (int'($urandom_range(99, 0)) >= recv_idle_pct);
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   task automatic send_bin(input logic [LIK_W-1:0] lik, input logic last);
      if (int'($urandom_range(99, 0)) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_likelihood <= lik;
      req_last_bin   <= last;
      do @(posedge clock); while (!req_ready);
      track_bin(lik, last);
      bins_sent++;
   endtask

   // background bins stay at or below the threshold so only peak_at can win
   task automatic send_frame(input int len, input int peak_at, input logic [LIK_W-1:0] peak_val);
      for (int i = 0; i < len; i++)
         send_bin((i == peak_at) ? peak_val : LIK_W'($urandom_range(int'(lik_min_cfg), 0)),
                  i == len - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      set_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed_frames();
      send_bin('1, 1'b1);
      send_bin('0, 1'b1);
      send_bin(lik_min_cfg, 1'b0);
      send_bin(lik_min_cfg + 1'b1, 1'b0);
      send_bin(lik_min_cfg + 1'b1, 1'b0);
      send_bin('0, 1'b1);
      // threshold lowered between two bins of one frame
      send_bin(LIK_W'(30000), 1'b0);
      settle();
      write_register(CSR_LIK_MIN, CSR_DATA_W'(20000));
      send_bin(LIK_W'(25000), 1'b1);
   endtask

   task automatic test_register_extremes();
      settle();
      write_register(CSR_LIK_MIN, '0);
      write_register(CSR_NEW_SRC, '0);
      write_register(CSR_CONSIST, '0);
      write_register(CSR_HOLD, '0);
      send_bin(LIK_W'(1), 1'b1);
      send_bin(LIK_W'(5), 1'b1);
      send_bin('0, 1'b1);
      settle();
      write_register(CSR_HOLD, '1);
      write_register(CSR_MAX_ANGLE, '1);
      write_register(CSR_CONSIST, CSR_DATA_W'(16'hFFF1));
      write_register(CSR_NEW_SRC, '1);
      send_bin('1, 1'b1);
      settle();
      write_register(CSR_NEW_SRC, CSR_DATA_W'(16'hFFFE));
      send_bin('0, 1'b0);
      send_bin('1, 1'b1);
      send_bin('0, 1'b1);
      send_bin('0, 1'b1);
      settle();
      write_register(CSR_LIK_MIN, '1);
      for (int idx = int'(CSR_HOLD) + 1; idx < (1 << CSR_IDX_W); idx++)
         write_register(CSR_IDX_W'(idx), CSR_DATA_W'($urandom));
      send_bin('1, 1'b1);
   endtask

   task automatic test_back_pressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      settle();
      write_register(CSR_LIK_MIN, CSR_DATA_W'(10000));
      write_register(CSR_NEW_SRC, CSR_DATA_W'(20000));
      write_register(CSR_MAX_ANGLE, CSR_DATA_W'(3));
      write_register(CSR_CONSIST, CSR_DATA_W'(2));
      write_register(CSR_HOLD, CSR_DATA_W'(4));
      hold_off_asked++;
      repeat (40) send_frame(int'($urandom_range(3, 1)), 0, LIK_W'($urandom_range(65535, 20001)));
      settle();
   endtask

   task automatic test_random_tracking(input int send_pct, input int recv_pct,
                                       input int bin_goal, input int report_goal);
      int                bins_start;
      int                reports_start;
      int                src;
      int                pos;
      int                len;
      logic              overlong;
      logic [LIK_W-1:0]  level;
      logic [LMIN_W-1:0] lmin;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      settle();
      lmin = LMIN_W'($urandom_range(30000, 1000));
      write_register(CSR_LIK_MIN, lmin);
      write_register(CSR_NEW_SRC, CSR_DATA_W'(lmin + $urandom_range(20000, 0)));
      write_register(CSR_MAX_ANGLE, CSR_DATA_W'($urandom_range(8, 0)));
      write_register(CSR_CONSIST, CSR_DATA_W'($urandom_range(5, 1)));
      write_register(CSR_HOLD, CSR_DATA_W'($urandom_range(15, 1)));
      bins_start    = bins_sent;
      reports_start = reports_checked;
      while (bins_sent - bins_start < bin_goal || reports_checked - reports_start < report_goal) begin
         case ($urandom_range(9, 0))
            0: begin
               len = int'($urandom_range(6, 1));
               for (int i = 0; i < len; i++) send_bin(LIK_W'($urandom), i == len - 1);
            end
            1: begin
               repeat ($urandom_range(6, 1)) send_frame(int'($urandom_range(3, 1)), -1, '0);
            end
            default: begin
               src = ($urandom_range(9, 0) < 7) ? int'($urandom_range(10, 0))
                                                : int'($urandom_range(NUM_BINS - 1, 0));
               repeat ($urandom_range(12, 3)) begin
                  pos = src + int'($urandom_range(4, 0)) - 2;
                  if (pos < 0) pos = 0;
                  if (pos > NUM_BINS - 1) pos = NUM_BINS - 1;
                  overlong = ($urandom_range(11, 0) == 0);
                  if (overlong) begin
                     len = NUM_BINS + 1 + int'($urandom_range(4, 0));
                     if ($urandom_range(1, 0) == 1)
                        pos = NUM_BINS + int'($urandom_range(len - NUM_BINS - 1, 0));
                  end else begin
                     len = pos + 1 + int'($urandom_range(3, 0));
                  end
                  if ($urandom_range(9, 0) < 8)
                     level = LIK_W'($urandom_range(65535, int'(new_src_cfg) + 1));
                  else
                     level = LIK_W'($urandom_range(65535, int'(lik_min_cfg) + 1));
                  send_frame(len, pos, level);
               end
            end
         endcase
      end
   endtask

   initial begin
      send_idle_pct    = 30;
      recv_idle_pct    = 52;
      bins_sent        = 0;
      reports_checked  = 0;
      mismatches       = 0;
      hold_off_asked   = 0;
      reset_tracker();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_register_extremes();
      test_random_tracking(30, 52, 180, 18);
      test_random_tracking(52, 30, 180, 18);
      test_back_pressure();
      test_random_tracking(0, 0, 180, 18);
      settle();
      $display("Covered %0d bins and %0d frame reports: edge frames, register extremes,",
               bins_sent, reports_checked);
      $display("a long receiver hold-off and three random idle mixes of source tracks.");
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
